// File: rtl/core/bwds_pkg.sv
// Shared types and codes for the burn-wire deployment sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package bwds_pkg;

  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned InUserW   = 3;
  localparam int unsigned OutDataW  = 72;

  localparam logic [15:0] BurnTicksRst    = 16'd8;
  localparam logic [7:0]  AttemptLimitRst = 8'd3;
  localparam logic [15:0] RetryTicksRst   = 16'd4;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_BURN_TICKS    = 2'd0,
    REG_ATTEMPT_LIMIT = 2'd1,
    REG_RETRY_TICKS   = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_TICK   = 3'd0,
    EV_DEPLOY = 3'd1,
    EV_STOP   = 3'd2,
    EV_CLEAR  = 3'd3,
    EV_SET    = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BURN = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    RESP_NONE = 2'd0,
    RESP_OK   = 2'd1,
    RESP_BUSY = 2'd2
  } resp_t;

  typedef enum logic [1:0] {
    FIN_NONE  = 2'd0,
    FIN_FAIL  = 2'd1,
    FIN_ABORT = 2'd2
  } finish_t;

  typedef struct packed {
    logic [15:0] burn_ticks;
    logic [7:0]  attempt_limit;
    logic [15:0] retry_ticks;
  } cfg_t;

  typedef struct packed {
    resp_t       response;
    logic        burn_start;
    logic        burn_stop;
    finish_t     finish_kind;
    logic [7:0]  attempt_now;
    logic [15:0] burn_tick_report;
    logic [31:0] attempts_before;
    logic        deployed;
    phase_t      phase_now;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/bwds_cfg_regs.sv
// APB-style register file for the sequencer settings.
// Depends on bwds_pkg for the register indexes and the settings struct.
`default_nettype none

module bwds_cfg_regs (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire  [bwds_pkg::CfgAddrW-1:0]      cfg_paddr,
  input  wire  [bwds_pkg::CfgDataW-1:0]      cfg_pwdata,
  output logic [bwds_pkg::CfgDataW-1:0]      cfg_prdata,
  output logic                               cfg_pready,
  output bwds_pkg::cfg_t                     cfg
);
  import bwds_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_BURN_TICKS:    cfg_nxt.burn_ticks    = cfg_pwdata[15:0];
        REG_ATTEMPT_LIMIT: cfg_nxt.attempt_limit = cfg_pwdata[7:0];
        REG_RETRY_TICKS:   cfg_nxt.retry_ticks   = cfg_pwdata[15:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BURN_TICKS:    cfg_prdata = {16'd0, cfg_r.burn_ticks};
      REG_ATTEMPT_LIMIT: cfg_prdata = {24'd0, cfg_r.attempt_limit};
      REG_RETRY_TICKS:   cfg_prdata = {16'd0, cfg_r.retry_ticks};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.burn_ticks    <= BurnTicksRst;
      cfg_r.attempt_limit <= AttemptLimitRst;
      cfg_r.retry_ticks   <= RetryTicksRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bwds_seq_core.sv
// Deployment sequence state and its single-pass next-state logic.
// Depends on bwds_pkg for event, phase and result types.
`default_nettype none

module bwds_seq_core (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     ev_fire,
  input  wire  [2:0]              ev_mode,
  input  wire                     ev_flag,
  input  bwds_pkg::cfg_t          cfg,
  output bwds_pkg::result_t       result
);
  import bwds_pkg::*;

  phase_t      phase_r,    phase_nxt;
  logic [7:0]  attempt_r,  attempt_nxt;
  logic [15:0] ticks_r,    ticks_nxt;
  logic [31:0] lifetime_r, lifetime_nxt;
  logic        deployed_r, deployed_nxt;

  event_t      ev;
  logic [15:0] ticks_inc;
  logic        limit_hit;

  // Ticks burned so far equal the phase tick count while burning and are zero
  // otherwise, so no separate burned-tick register is kept.
  assign ev        = event_t'(ev_mode);
  assign ticks_inc = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
  assign limit_hit = (attempt_r >= cfg.attempt_limit);

  always_comb begin
    phase_nxt    = phase_r;
    attempt_nxt  = attempt_r;
    ticks_nxt    = ticks_r;
    lifetime_nxt = lifetime_r;
    deployed_nxt = deployed_r;
    result       = '0;

    unique case (ev)
      EV_TICK: begin
        unique case (phase_r)
          PH_BURN: begin
            ticks_nxt = ticks_inc;
            if (ticks_inc >= cfg.burn_ticks) begin
              result.burn_stop        = 1'b1;
              result.burn_tick_report = ticks_inc;
              ticks_nxt               = '0;
              if (limit_hit) begin
                deployed_nxt       = 1'b1;
                result.finish_kind = FIN_FAIL;
                phase_nxt          = PH_IDLE;
                attempt_nxt        = '0;
              end else begin
                phase_nxt = PH_WAIT;
              end
            end
          end
          PH_WAIT: begin
            ticks_nxt = ticks_inc;
            if (cfg.retry_ticks == 16'd0 || ticks_inc >= cfg.retry_ticks) begin
              ticks_nxt = '0;
              if (limit_hit) begin
                result.burn_stop   = 1'b1;
                deployed_nxt       = 1'b1;
                result.finish_kind = FIN_FAIL;
                phase_nxt          = PH_IDLE;
                attempt_nxt        = '0;
              end else begin
                attempt_nxt            = (attempt_r == 8'hFF) ? attempt_r
                                                              : attempt_r + 8'd1;
                result.attempts_before = lifetime_r;
                lifetime_nxt           = (lifetime_r == 32'hFFFF_FFFF) ? lifetime_r
                                                                      : lifetime_r + 32'd1;
                result.burn_start      = 1'b1;
                phase_nxt              = PH_BURN;
              end
            end
          end
          default: ;
        endcase
      end
      EV_DEPLOY: begin
        priority if (deployed_r) begin
          result.response = RESP_OK;
        end else if (phase_r != PH_IDLE) begin
          result.response = RESP_BUSY;
        end else begin
          result.response        = RESP_OK;
          attempt_nxt            = 8'd1;
          ticks_nxt              = '0;
          result.attempts_before = lifetime_r;
          lifetime_nxt           = (lifetime_r == 32'hFFFF_FFFF) ? lifetime_r
                                                                : lifetime_r + 32'd1;
          result.burn_start      = 1'b1;
          phase_nxt              = PH_BURN;
        end
      end
      EV_STOP: begin
        result.response = RESP_OK;
        if (phase_r != PH_IDLE) begin
          result.burn_stop   = 1'b1;
          result.finish_kind = FIN_ABORT;
          if (phase_r == PH_BURN) result.burn_tick_report = ticks_r;
          phase_nxt   = PH_IDLE;
          attempt_nxt = '0;
          ticks_nxt   = '0;
        end
      end
      EV_CLEAR: begin
        result.response = RESP_OK;
        deployed_nxt    = 1'b0;
      end
      EV_SET: begin
        result.response = RESP_OK;
        deployed_nxt    = ev_flag;
      end
      default: ;
    endcase

    result.attempt_now = attempt_nxt;
    result.deployed    = deployed_nxt;
    result.phase_now   = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      attempt_r  <= '0;
      ticks_r    <= '0;
      lifetime_r <= '0;
      deployed_r <= 1'b0;
    end else if (ev_fire) begin
      phase_r    <= phase_nxt;
      attempt_r  <= attempt_nxt;
      ticks_r    <= ticks_nxt;
      lifetime_r <= lifetime_nxt;
      deployed_r <= deployed_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/burn_wire_deploy_sequencer_top.sv
// An accepted request reaches out_tvalid through the input register and then the result register;
// one request per cycle while out_tready stays high. A request is held in the input register, worked
// in one pass through the sequence logic and written to the result register with the new sequence state.
// Reset (rst_n, synchronous, active low): phase idle, counters and deployed flag cleared,
// settings back to burn 8, attempt limit 3, retry 4; both stream stages emptied.
// Depends on bwds_pkg, bwds_cfg_regs and bwds_seq_core.
`default_nettype none

module burn_wire_deploy_sequencer_top (
  input  wire                                clk,
  input  wire                                rst_n,
  // input stream
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [bwds_pkg::InDataW-1:0]       in_tdata,   // [0] flag_value, rest zero
  input  wire  [bwds_pkg::InUserW-1:0]       in_tuser,   // [2:0] mode
  // result stream
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [1:0] response, [2] burn_start, [3] burn_stop, [5:4] finish_kind,
  // [13:6] attempt_now, [29:14] burn_tick_report, [61:30] attempts_before,
  // [62] deployed, [64:63] phase_now, [71:65] zero
  output logic [bwds_pkg::OutDataW-1:0]      out_tdata,
  // configuration
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire  [bwds_pkg::CfgAddrW-1:0]      cfg_paddr,
  input  wire  [bwds_pkg::CfgDataW-1:0]      cfg_pwdata,
  output logic [bwds_pkg::CfgDataW-1:0]      cfg_prdata,
  output logic                               cfg_pready
);
  import bwds_pkg::*;

  cfg_t    cfg;
  result_t core_res;

  // Input stage: one request held ahead of the sequence logic.
  logic       in_valid_r, in_valid_nxt;
  logic [2:0] in_mode_r;
  logic       in_flag_r;

  // Result stage.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic out_adv;   // result register free or draining this cycle
  logic fire;      // held request passes through the sequence logic
  logic in_acc;

  assign out_adv   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_adv;
  assign in_tready = !in_valid_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc)    in_valid_nxt = 1'b1;
    else if (fire) in_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (fire)            out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: input payload loads on accept, result loads on fire; both hold otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_mode_r <= in_tuser[2:0];
      in_flag_r <= in_tdata[0];
    end
    if (fire) out_res_r <= core_res;
  end

  bwds_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bwds_seq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ev_fire (fire),
    .ev_mode (in_mode_r),
    .ev_flag (in_flag_r),
    .cfg     (cfg),
    .result  (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0,
                       out_res_r.phase_now,
                       out_res_r.deployed,
                       out_res_r.attempts_before,
                       out_res_r.burn_tick_report,
                       out_res_r.attempt_now,
                       out_res_r.finish_kind,
                       out_res_r.burn_stop,
                       out_res_r.burn_start,
                       out_res_r.response};

endmodule

`default_nettype wire

// File: tb/burn_wire_deploy_sequencer_top_test.sv
// Self-checking bench for the burn-wire deployment sequencer: streams event requests into the
// block, predicts each answer in step with it and compares every answer field by field.
// Depends on bwds_pkg and burn_wire_deploy_sequencer_top.

module burn_wire_deploy_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bwds_pkg::*;

  // Event codes above EV_SET are not events at all; the block answers them with no response
  // and leaves its state alone
  localparam logic [2:0]  EvUnusedFirst  = 3'd5;
  localparam logic [2:0]  EvUnusedLast   = 3'd7;
  localparam int unsigned RandomRequests = 650;
  localparam int unsigned HoldCycles     = 150;
  localparam int unsigned RunLimitNs     = 2_000_000;

  typedef struct packed {
    logic [2:0] mode;
    logic       flag;
  } event_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  wire                 in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [InUserW-1:0]  in_tuser = '0;
  wire                 out_tvalid;
  logic                out_tready = 1'b0;
  wire [OutDataW-1:0]  out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [CfgDataW-1:0] cfg_pwdata = '0;
  wire [CfgDataW-1:0]  cfg_prdata;
  wire                 cfg_pready;

  burn_wire_deploy_sequencer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial forever #2 clk = ~clk;

  // Limit on the whole run: far beyond the slowest correct run
  initial begin
    #RunLimitNs;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequencer prediction: own copy of the settings and of the sequence state
  // ---------------------------------------------------------------------------
  logic [15:0] burn_len    = BurnTicksRst;
  logic [7:0]  attempt_max = AttemptLimitRst;
  logic [15:0] retry_len   = RetryTicksRst;

  phase_t      seq_phase     = PH_IDLE;
  logic [7:0]  attempt_cnt   = '0;
  logic [15:0] phase_cnt     = '0;
  logic [15:0] burned_cnt    = '0;
  logic [31:0] lifetime_cnt  = '0;
  logic        deployed_flag = 1'b0;

  result_t     answer;
  result_t     pending_answers[$];

  event_req_t  event_queue[$];
  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned answered_count = 0;
  int unsigned error_count    = 0;

  // Raise the burn for the next attempt; counters stop at their maximum
  function automatic void start_attempt();
    if (attempt_cnt != 8'hFF) attempt_cnt++;
    phase_cnt = '0;
    answer.attempts_before = lifetime_cnt;
    if (lifetime_cnt != 32'hFFFF_FFFF) lifetime_cnt++;
    burned_cnt = '0;
    answer.burn_start = 1'b1;
    seq_phase = PH_BURN;
  endfunction

  // Drop the sequence back to idle; a failed finish marks the antenna as deployed
  function automatic void end_sequence(finish_t kind);
    if (seq_phase == PH_IDLE) return;
    answer.burn_stop = 1'b1;
    if (burned_cnt != '0) begin
      answer.burn_tick_report = burned_cnt;
      burned_cnt = '0;
    end
    if (kind == FIN_FAIL) deployed_flag = 1'b1;
    answer.finish_kind = kind;
    seq_phase   = PH_IDLE;
    attempt_cnt = '0;
    phase_cnt   = '0;
    burned_cnt  = '0;
  endfunction

  // Advance the sequence by one accepted request and store the answer it must give
  function automatic void step_sequence(event_req_t req);
    answer = '0;
    case (req.mode)
      EV_TICK: begin
        if (seq_phase == PH_BURN) begin
          if (phase_cnt != 16'hFFFF) phase_cnt++;
          burned_cnt = phase_cnt;
          if (phase_cnt >= burn_len) begin
            answer.burn_stop = 1'b1;
            answer.burn_tick_report = burned_cnt;
            burned_cnt = '0;
            if (attempt_cnt >= attempt_max) end_sequence(FIN_FAIL);
            else begin
              seq_phase = PH_WAIT;
              phase_cnt = '0;
            end
          end
        end else if (seq_phase == PH_WAIT) begin
          if (phase_cnt != 16'hFFFF) phase_cnt++;
          // the limit is looked at again here, so a lowered limit ends the wait as failed
          if (retry_len == '0 || phase_cnt >= retry_len) begin
            if (attempt_cnt >= attempt_max) end_sequence(FIN_FAIL);
            else start_attempt();
          end
        end
      end
      EV_DEPLOY: begin
        if (deployed_flag) answer.response = RESP_OK;
        else if (seq_phase != PH_IDLE) answer.response = RESP_BUSY;
        else begin
          attempt_cnt = '0;
          phase_cnt   = '0;
          burned_cnt  = '0;
          start_attempt();
          answer.response = RESP_OK;
        end
      end
      EV_STOP: begin
        answer.response = RESP_OK;
        end_sequence(FIN_ABORT);
      end
      EV_CLEAR: begin
        deployed_flag = 1'b0;
        answer.response = RESP_OK;
      end
      EV_SET: begin
        deployed_flag = req.flag;
        answer.response = RESP_OK;
      end
      default: ;
    endcase
    answer.attempt_now = attempt_cnt;
    answer.deployed    = deployed_flag;
    answer.phase_now   = seq_phase;
    pending_answers.push_back(answer);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps between them
  // ---------------------------------------------------------------------------
  event_req_t  on_bus;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // the request on the bus was taken at this edge: predict its answer now
      if (in_tvalid && in_tready) begin
        step_sequence(on_bus);
        accepted_count++;
      end
      // hold a request that is still waiting; otherwise offer the next or idle
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (event_queue.size() == 0) begin
          in_tvalid <= 1'b0;
        end else begin
          on_bus = event_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= on_bus.mode;
          in_tdata  <= {{(InDataW-1){1'b0}}, on_bus.flag};
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 23);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              3:       gap_left = $urandom_range(10, 40);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Answer monitor: full-rate stretches, random stalls, and two long hold-offs
  // that back the block up until it refuses requests
  // ---------------------------------------------------------------------------
  result_t     oldest_answer;
  int unsigned hold_left = 0;
  int unsigned rx_cycle  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          $error("answer with no request outstanding: %h", out_tdata);
          error_count++;
        end else begin
          oldest_answer = pending_answers.pop_front();
          check_field("response", 32'(oldest_answer.response), 32'(out_tdata[1:0]));
          check_field("burn_start", 32'(oldest_answer.burn_start), 32'(out_tdata[2]));
          check_field("burn_stop", 32'(oldest_answer.burn_stop), 32'(out_tdata[3]));
          check_field("finish_kind", 32'(oldest_answer.finish_kind), 32'(out_tdata[5:4]));
          check_field("attempt_now", 32'(oldest_answer.attempt_now), 32'(out_tdata[13:6]));
          check_field("burn_tick_report", 32'(oldest_answer.burn_tick_report),
                      32'(out_tdata[29:14]));
          check_field("attempts_before", oldest_answer.attempts_before, out_tdata[61:30]);
          check_field("deployed", 32'(oldest_answer.deployed), 32'(out_tdata[62]));
          check_field("phase_now", 32'(oldest_answer.phase_now), 32'(out_tdata[64:63]));
        end
        answered_count++;
        if (answered_count == 300 || answered_count == 1100) hold_left = HoldCycles;
      end
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_cycle % 400 < 120) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_event(logic [2:0] mode, logic flag);
    event_req_t req;
    req.mode = mode;
    req.flag = flag;
    event_queue.push_back(req);
    queued_count++;
  endfunction

  function automatic void queue_ticks(int unsigned n);
    repeat (n) queue_event(EV_TICK, 1'b0);
  endfunction

  // Pause the sender until every queued request has been answered
  task automatic wait_drained();
    while (accepted_count != queued_count || pending_answers.size() != 0) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge
  task automatic write_reg(reg_idx_t idx, logic [CfgDataW-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_BURN_TICKS:    burn_len    = value[15:0];
      REG_ATTEMPT_LIMIT: attempt_max = value[7:0];
      REG_RETRY_TICKS:   retry_len   = value[15:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(logic [15:0] burn, logic [7:0] limit, logic [15:0] retry);
    write_reg(REG_BURN_TICKS, {16'd0, burn});
    write_reg(REG_ATTEMPT_LIMIT, {24'd0, limit});
    write_reg(REG_RETRY_TICKS, {16'd0, retry});
  endtask

  int unsigned random_done;
  int unsigned pick;
  logic [2:0]  rand_mode;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: idle commands, unused codes, flag handling, busy and abort
    queue_event(EV_TICK, 1'b0);
    queue_event(EV_STOP, 1'b0);
    queue_event(EvUnusedFirst, 1'b1);
    queue_event(EvUnusedLast, 1'b0);
    queue_event(EV_SET, 1'b1);
    queue_event(EV_DEPLOY, 1'b0);       // already deployed: plain OK
    queue_event(EV_SET, 1'b0);
    queue_event(EV_DEPLOY, 1'b0);
    queue_event(EV_DEPLOY, 1'b0);       // busy while burning
    queue_ticks(3);
    queue_event(EV_STOP, 1'b1);         // abort mid-burn, reports the ticks burned
    queue_event(EV_CLEAR, 1'b1);
    queue_event(EV_DEPLOY, 1'b0);
    queue_ticks(8);                     // burn runs out, enter the retry wait
    queue_event(EV_DEPLOY, 1'b0);       // busy while waiting
    queue_event(EV_SET, 1'b0);          // flag commands leave the sequence alone
    wait_drained();

    // Lower the attempt limit while the retry wait runs: the wait ends in a failed finish
    write_reg(REG_ATTEMPT_LIMIT, 32'd1);
    queue_ticks(5);
    wait_drained();

    // Lowest settings: the burn ends on its first tick, no retries
    write_settings(16'd0, 8'd0, 16'd0);
    queue_event(EV_DEPLOY, 1'b0);
    queue_event(EV_CLEAR, 1'b0);
    queue_event(EV_DEPLOY, 1'b0);
    queue_ticks(2);
    queue_event(EV_CLEAR, 1'b0);
    queue_event(EV_DEPLOY, 1'b0);
    queue_event(EV_STOP, 1'b0);         // abort before any tick was burned
    wait_drained();

    // Zero retry delay restarts on the next tick
    write_settings(16'd1, 8'd2, 16'd0);
    queue_event(EV_CLEAR, 1'b0);
    queue_event(EV_DEPLOY, 1'b0);
    queue_ticks(6);
    wait_drained();

    // Highest settings: start a long burn, then abort it
    write_settings(16'hFFFF, 8'hFF, 16'hFFFF);
    queue_event(EV_CLEAR, 1'b0);
    queue_event(EV_DEPLOY, 1'b0);
    queue_ticks(30);
    queue_event(EV_STOP, 1'b0);
    wait_drained();

    // Run every attempt up to the highest limit with the shortest burn and no wait
    write_settings(16'd0, 8'hFF, 16'd0);
    queue_event(EV_CLEAR, 1'b0);
    queue_event(EV_DEPLOY, 1'b0);
    queue_ticks(515);
    wait_drained();

    // Random phases: mostly ticks so sequences run to their end, settings changed
    // between phases whatever state the sequence is in
    random_done = 0;
    while (random_done < RandomRequests) begin
      if ($urandom_range(0, 7) == 0)
        write_settings(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)));
      else
        write_settings(16'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
                       16'($urandom_range(0, 5)));
      repeat ($urandom_range(40, 160)) begin
        pick = $urandom_range(0, 99);
        if (pick < 72)      rand_mode = EV_TICK;
        else if (pick < 82) rand_mode = EV_DEPLOY;
        else if (pick < 87) rand_mode = EV_STOP;
        else if (pick < 93) rand_mode = EV_CLEAR;
        else if (pick < 97) rand_mode = EV_SET;
        else                rand_mode = 3'($urandom_range(EvUnusedFirst, EvUnusedLast));
        queue_event(rand_mode, 1'($urandom_range(0, 1)));
        if (rand_mode <= EV_SET) random_done++;
      end
      wait_drained();
    end

    // Let the pipeline settle so any stray answer shows up
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_answers.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bwds_pkg.sv
rtl/core/bwds_cfg_regs.sv
rtl/core/bwds_seq_core.sv
rtl/core/burn_wire_deploy_sequencer_top.sv
tb/burn_wire_deploy_sequencer_top_test.sv
